/* hdl/b32e_pkg.sv */
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types and constants of the lsb-first base32 encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  // input command codes
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int GROUP_BITS = 5;
  localparam int ACC_BITS   = 12;
  localparam int CNT_BITS   = 4;
  localparam int PAD_BITS   = 3;
  localparam int SYM_BITS   = 7;

  localparam logic [SYM_BITS-1:0] PAD_SYMBOL = 7'd61;

  // punctuation alphabet, indexed by 5-bit group
  localparam logic [SYM_BITS-1:0] ALPHABET [0:31] = '{
    7'd126, 7'd96,  7'd34,  7'd39,  7'd94,  7'd33,  7'd64,  7'd35,
    7'd36,  7'd37,  7'd38,  7'd45,  7'd43,  7'd47,  7'd124, 7'd92,
    7'd32,  7'd40,  7'd41,  7'd123, 7'd125, 7'd91,  7'd93,  7'd60,
    7'd62,  7'd58,  7'd59,  7'd44,  7'd46,  7'd95,  7'd42,  7'd63
  };

  // commands from controller to datapath
  typedef struct packed {
    logic load_byte;
    logic load_flush;
    logic emit_group;
    logic emit_flush;
    logic emit_pad;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic pend_zero;
    logic group_last;
    logic pad_zero;
    logic pad_one;
  } dp_status_t;

  // pads that follow the flush symbol, by pending bit count
  function automatic logic [PAD_BITS-1:0] pad_count(input logic [2:0] cnt);
    logic [PAD_BITS-1:0] res;
    case (cnt)
      3'd1:    res = 3'd4;
      3'd2:    res = 3'd1;
      3'd3:    res = 3'd6;
      3'd4:    res = 3'd3;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

/* hdl/b32e_ctrl.sv */
// ----------------------------------------------------------------------------
// b32e_ctrl
// Controller: accepts input words and sequences symbol emission.
// ----------------------------------------------------------------------------
module b32e_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  b32e_pkg::dp_status_t status,
  output b32e_pkg::dp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_FLUSH,
    ST_PAD
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == b32e_pkg::CMD_DATA) begin
            cmd.load_byte = 1'b1;
            state_nxt     = ST_DATA;
          end else begin
            cmd.load_flush = 1'b1;
            if (!status.pend_zero) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_DATA: begin
        if (status.out_free) begin
          cmd.emit_group = 1'b1;
          if (status.group_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_flush = 1'b1;
          state_nxt      = status.pad_zero ? ST_IDLE : ST_PAD;
        end
      end
      ST_PAD: begin
        if (status.out_free) begin
          cmd.emit_pad = 1'b1;
          if (status.pad_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/b32e_dp.sv */
// ----------------------------------------------------------------------------
// b32e_dp
// Datapath: bit accumulator, pad counter and output register.
// ----------------------------------------------------------------------------
module b32e_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_data_byte,
  input  b32e_pkg::dp_cmd_t    cmd,
  output b32e_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           out_symbol,
  output logic                 out_last_of_run
);

  logic [b32e_pkg::ACC_BITS-1:0] acc_r, acc_nxt;
  logic [b32e_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [b32e_pkg::PAD_BITS-1:0] pad_r, pad_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [b32e_pkg::SYM_BITS-1:0] out_symbol_r, out_symbol_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          emitting;
  logic [b32e_pkg::SYM_BITS-1:0] group_sym;

  assign emitting  = cmd.emit_group || cmd.emit_flush || cmd.emit_pad;
  assign group_sym = b32e_pkg::ALPHABET[acc_r[4:0]];

  assign status.out_free   = !(out_valid_r && out_stall);
  assign status.pend_zero  = (cnt_r == '0);
  assign status.group_last = (cnt_r < 4'd10);
  assign status.pad_zero   = (pad_r == '0);
  assign status.pad_one    = (pad_r == 3'd1);

  always_comb begin
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    pad_nxt        = pad_r;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    // new byte lands just above the pending bits
    if (cmd.load_byte) begin
      acc_nxt = acc_r | ({4'b0, in_data_byte} << cnt_r[2:0]);
      cnt_nxt = cnt_r + 4'd8;
    end
    if (cmd.load_flush) begin
      pad_nxt = b32e_pkg::pad_count(cnt_r[2:0]);
      if (cnt_r == '0) begin
        acc_nxt = '0;
      end
    end
    if (cmd.emit_group) begin
      acc_nxt        = acc_r >> b32e_pkg::GROUP_BITS;
      cnt_nxt        = cnt_r - 4'd5;
      out_symbol_nxt = group_sym;
      out_last_nxt   = (cnt_r < 4'd10);
    end
    if (cmd.emit_flush) begin
      acc_nxt        = '0;
      cnt_nxt        = '0;
      out_symbol_nxt = group_sym;
      out_last_nxt   = (pad_r == '0);
    end
    if (cmd.emit_pad) begin
      pad_nxt        = pad_r - 3'd1;
      out_symbol_nxt = b32e_pkg::PAD_SYMBOL;
      out_last_nxt   = (pad_r == 3'd1);
    end
    if (emitting) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      pad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      pad_r       <= pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_symbol_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd12)
    else $error("pending bit count out of range");

  a_group_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_group |-> cnt_r >= 4'd5)
    else $error("group emitted with fewer than five bits");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pad |-> pad_r != '0)
    else $error("pad emitted with pad count zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emitting && out_valid_r) |-> !out_stall)
    else $error("output register overwritten while stalled");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emitting |=> out_valid_r)
    else $error("emitted symbol not presented");
`endif

endmodule

/* hdl/base32_lsb_first_encoder.sv */
// ----------------------------------------------------------------------------
// base32_lsb_first_encoder
// Streaming base32 encoder, lsb-first packing, punctuation alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel carries one word per item: in_command 0 with in_data_byte
//   appends a byte, in_command 1 ends the message (flush and '=' padding).
//   out_ channel carries one symbol per word; out_last_of_run marks the
//   final symbol caused by an input word.
// Timing:
//   a data byte yields one or two symbols; the first is presented from the
//   output register after the controller's data state, then one symbol per
//   cycle while out_stall is low. The next input word is taken only once the
//   controller is back in idle. A flush with nothing pending emits no symbol,
//   else the flush symbol followed by up to six pads.
//   in_stall is high while the controller is emitting symbols of a word.
// Reset:
//   synchronous active-low rst_n clears the accumulator, pending count, pad
//   count, output valid and the controller state.
// Backpressure:
//   out_stall holds the current symbol and pauses emission; the last symbol
//   may wait in the output register while the next input word is taken.
// ----------------------------------------------------------------------------
module base32_lsb_first_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_symbol,
  output logic       out_last_of_run
);

  b32e_pkg::dp_cmd_t    cmd;
  b32e_pkg::dp_status_t status;

  b32e_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .status     (status),
    .cmd        (cmd)
  );

  b32e_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lsb-first base32 encoder. Messages of random
// length and content are pushed through the input channel with bursty
// timing while the output side stalls on its own pattern; each symbol is
// compared against a behavioral encoder kept alongside the stimulus.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [6:0] symbol;
    logic       last;
  } glyph_t;

  // punctuation alphabet, one entry per 5-bit group
  localparam logic [6:0] GLYPHS [0:31] = '{
    7'd126, 7'd96,  7'd34,  7'd39,  7'd94,  7'd33,  7'd64,  7'd35,
    7'd36,  7'd37,  7'd38,  7'd45,  7'd43,  7'd47,  7'd124, 7'd92,
    7'd32,  7'd40,  7'd41,  7'd123, 7'd125, 7'd91,  7'd93,  7'd60,
    7'd62,  7'd58,  7'd59,  7'd44,  7'd46,  7'd95,  7'd42,  7'd63
  };
  localparam logic [6:0] PAD_GLYPH = 7'h3d;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = b32e_pkg::CMD_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_symbol;
  logic       out_last_of_run;

  // encoder state mirrored by the bench
  logic [11:0] enc_acc = '0;
  logic [3:0]  enc_bits = '0;
  logic [2:0]  msg_syms = '0;
  glyph_t      expected_glyphs[$];

  int errors = 0;
  int words_sent = 0;
  int flushes_sent = 0;
  int glyphs_seen = 0;
  int burst_left = 0;
  int max_gap = 0;
  int stall_mode = 0;
  int stall_pct = 0;
  int stall_left = 0;

  base32_lsb_first_encoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run)
  );

  always #1 clk = ~clk;

  initial begin
    #500000;
    $display("FAIL");
    $finish;
  end

  // output stall pattern: off, short blips, or long holds
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_mode != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, (stall_mode == 2) ? 6 : 1);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // symbols expected from one accepted word
  task automatic encode_word(input logic cmd, input logic [7:0] data);
    logic [15:0] acc;
    int          cnt;
    int          n;
    glyph_t      run [0:7];
    n = 0;
    if (cmd == b32e_pkg::CMD_DATA) begin
      acc = (16'(enc_acc) & ((16'd1 << enc_bits) - 16'd1)) | (16'(data) << enc_bits);
      cnt = enc_bits + 8;
      while (cnt >= 5) begin
        run[n] = '{GLYPHS[acc[4:0]], 1'b0};
        n++;
        msg_syms++;
        acc = acc >> 5;
        cnt -= 5;
      end
      enc_acc = acc[11:0];
      enc_bits = 4'(cnt);
    end else begin
      if (enc_bits != 0) begin
        acc = 16'(enc_acc) & ((16'd1 << enc_bits) - 16'd1);
        run[n] = '{GLYPHS[acc[4:0]], 1'b0};
        n++;
        msg_syms++;
        // pad until the message is a whole number of 8-symbol blocks
        while (msg_syms != 0) begin
          run[n] = '{PAD_GLYPH, 1'b0};
          n++;
          msg_syms++;
        end
      end
      enc_acc = '0;
      enc_bits = '0;
      msg_syms = '0;
    end
    for (int i = 0; i < n; i++) begin
      run[i].last = (i == n - 1);
      expected_glyphs.push_back(run[i]);
    end
  endtask

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic cmd, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_byte <= data;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    encode_word(cmd, data);
    words_sent++;
    if (cmd == b32e_pkg::CMD_FLUSH) flushes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_glyphs.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input glyph_t exp);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected sym %0d last %0b, got sym %0d last %0b",
               what, exp.symbol, exp.last, out_symbol, out_last_of_run);
  endtask

  // result checker, sampled mid-cycle so values are settled for the next edge
  initial begin : result_check
    glyph_t exp;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        glyphs_seen++;
        if (expected_glyphs.size() == 0) begin
          report_mismatch("unexpected word", '0);
        end else begin
          exp = expected_glyphs.pop_front();
          if (out_symbol !== exp.symbol || out_last_of_run !== exp.last)
            report_mismatch("field", exp);
        end
      end
    end
  end

  task automatic test_empty_flush();
    send_word(b32e_pkg::CMD_FLUSH, 8'hA5);
    send_word(b32e_pkg::CMD_FLUSH, 8'h00);
    send_word(b32e_pkg::CMD_DATA, 8'hFF);
    send_word(b32e_pkg::CMD_FLUSH, 8'hFF);
    send_word(b32e_pkg::CMD_FLUSH, 8'h5A);
  endtask

  // message lengths 1..5 leave 3, 1, 4, 2 and 0 bits pending
  task automatic test_pad_lengths();
    logic [7:0] bytes [0:14] = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF,
                                 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hFF, 8'hFF,
                                 8'hFF, 8'hFF, 8'hFF};
    int k;
    k = 0;
    for (int len = 1; len <= 5; len++) begin
      for (int i = 0; i < len; i++) begin
        send_word(b32e_pkg::CMD_DATA, bytes[k]);
        k++;
      end
      send_word(b32e_pkg::CMD_FLUSH, 8'(len * 8'h33));
    end
  endtask

  task automatic test_random_messages(input int items);
    int len;
    while (items > 0) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < len && items > 0; i++) begin
        case ($urandom_range(0, 9))
          0:       send_word(b32e_pkg::CMD_DATA, 8'h00);
          1:       send_word(b32e_pkg::CMD_DATA, 8'hFF);
          default: send_word(b32e_pkg::CMD_DATA, 8'($urandom));
        endcase
        items--;
      end
      send_word(b32e_pkg::CMD_FLUSH, 8'($urandom));
      items--;
    end
  endtask

  task automatic test_drain_pause();
    send_word(b32e_pkg::CMD_DATA, 8'($urandom));
    send_word(b32e_pkg::CMD_DATA, 8'($urandom));
    send_word(b32e_pkg::CMD_DATA, 8'($urandom));
    wait_drained();
    send_word(b32e_pkg::CMD_FLUSH, 8'($urandom));
    wait_drained();
  endtask

  initial begin : main
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_flush();
    test_pad_lengths();

    // back to back, no stalls
    max_gap = 0;
    stall_mode = 0;
    test_random_messages(55);
    test_drain_pause();

    // light idling on both sides
    max_gap = 2;
    stall_mode = 1;
    stall_pct = 25;
    test_random_messages(60);
    test_drain_pause();

    // long gaps and long output holds
    max_gap = 6;
    stall_mode = 2;
    stall_pct = 40;
    test_random_messages(60);

    wait_drained();
    stall_mode = 0;
    repeat (16) @(posedge clk);

    $display("sent %0d words including %0d end-of-message, checked %0d symbols",
             words_sent, flushes_sent, glyphs_seen);
    $display("pad lengths for every pending count, empty flush, stalls and gaps");
    if (errors == 0 && expected_glyphs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* base32_lsb_first_encoder.f */
hdl/b32e_pkg.sv
hdl/b32e_ctrl.sv
hdl/b32e_dp.sv
hdl/base32_lsb_first_encoder.sv
sim/testbench.sv
